// ===== hdl/apt_pkg.sv =====
// Shared types and constants for the aging peer table.
// Used by apt_cell and aging_peer_table; depends on nothing else.
package apt_pkg;

	localparam int unsigned IDX_W = 8;
	localparam int unsigned EXP_W = 5;
	localparam int unsigned DEAD_W = 16;

	localparam logic [7:0] KIND_ANNOUNCE = 8'd0;
	localparam logic [7:0] KIND_DISCONNECT = 8'd1;

	localparam logic [2:0] ACT_REFRESHED = 3'd0;
	localparam logic [2:0] ACT_REMOVED = 3'd1;
	localparam logic [2:0] ACT_INSERTED = 3'd2;
	localparam logic [2:0] ACT_NOOP = 3'd3;
	localparam logic [2:0] ACT_FULL = 3'd4;
	localparam logic [2:0] ACT_NOT_FOUND = 3'd5;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

	typedef struct packed {
		logic [7:0] req_type;
		logic [63:0] peer_name;
		logic [31:0] peer_addr;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic [2:0] action;
		logic [3:0] slot_index;
		logic [4:0] expired_count;
	} out_item_t;

	// Sweep token handed from one cell to the next.
	typedef struct packed {
		logic go;
		logic matched;
		logic [2:0] action;
		logic [IDX_W-1:0] hit_idx;
		logic free_found;
		logic [IDX_W-1:0] free_idx;
		logic [EXP_W-1:0] expired;
	} carry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
	} ins_t;

endpackage

// ===== hdl/apt_cell.sv =====
// One slot of the peer table: ages, matches and updates its own entry
// when the sweep token passes. Depends on apt_pkg.
module apt_cell #(
	parameter logic [apt_pkg::IDX_W-1:0] CELL_IDX = '0
) (
	input logic clk,
	input logic arst_n,
	input apt_pkg::in_item_t req,
	input logic [apt_pkg::DEAD_W-1:0] age_limit,
	input apt_pkg::carry_t carry_in,
	input apt_pkg::ins_t ins,
	output apt_pkg::carry_t carry_out
);

	logic valid_q;
	logic [63:0] name_q;
	logic [31:0] addr_q;
	logic [31:0] last_q;
	apt_pkg::carry_t carry_q;

	logic [31:0] age;
	logic aged;
	logic live;
	logic hit;
	logic ins_here;
	apt_pkg::carry_t carry_d;

	assign age = req.now_seconds - last_q;
	assign aged = valid_q && (age > {16'd0, age_limit});
	assign live = valid_q && !aged;
	assign hit = live && !carry_in.matched && (req.peer_name != 64'd0)
		&& (name_q == req.peer_name) && (addr_q == req.peer_addr);
	assign ins_here = ins.en && (ins.idx == CELL_IDX);

	always_comb begin
		carry_d = carry_in;
		if (carry_in.go) begin
			if (aged && carry_in.expired != apt_pkg::EXP_MAX) begin
				carry_d.expired = carry_in.expired + 1'b1;
			end
			if (hit) begin
				carry_d.matched = 1'b1;
				carry_d.hit_idx = CELL_IDX;
				priority if (req.req_type == apt_pkg::KIND_DISCONNECT) begin
					carry_d.action = apt_pkg::ACT_REMOVED;
				end else if (req.req_type == apt_pkg::KIND_ANNOUNCE) begin
					carry_d.action = apt_pkg::ACT_REFRESHED;
				end else begin
					carry_d.action = apt_pkg::ACT_NOOP;
				end
			end
			if (!live && !carry_in.free_found) begin
				carry_d.free_found = 1'b1;
				carry_d.free_idx = CELL_IDX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
			if (ins_here) begin
				valid_q <= 1'b1;
			end else if (carry_in.go) begin
				if (aged || (hit && req.req_type == apt_pkg::KIND_DISCONNECT)) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_here) begin
			name_q <= req.peer_name;
			addr_q <= req.peer_addr;
			last_q <= req.now_seconds;
		end else if (carry_in.go && hit && req.req_type == apt_pkg::KIND_ANNOUNCE) begin
			last_q <= req.now_seconds;
		end
	end

	assign carry_out = carry_q;

endmodule

// ===== hdl/aging_peer_table.sv =====
// Aging peer table: an accepted item is registered with the go flag, the sweep
// token passes through the TABLE_DEPTH cell registers at one cell per cycle, and
// done and result are registered from the chain end; no new item is taken until
// then. done pulses for one cycle; result holds to the next; no receiver stall.
// Reset clears every slot's valid bit and sets the age limit to 30.
// Depends on apt_pkg and apt_cell.
module aging_peer_table #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input apt_pkg::in_item_t item,
	input logic cfg_we,
	input logic [apt_pkg::DEAD_W-1:0] cfg_wdata,
	output logic done,
	output apt_pkg::out_item_t result
);

	logic [apt_pkg::DEAD_W-1:0] dead_q;
	apt_pkg::in_item_t req_q;
	logic busy_q;
	logic go_q;
	logic done_q;
	apt_pkg::out_item_t result_q;

	apt_pkg::carry_t chain [0:TABLE_DEPTH];
	apt_pkg::carry_t fin;
	apt_pkg::ins_t ins;
	apt_pkg::out_item_t result_d;
	logic accept;
	logic is_announce;

	assign accept = start && !busy_q;
	assign fin = chain[TABLE_DEPTH];
	assign is_announce = (req_q.req_type == apt_pkg::KIND_ANNOUNCE);

	always_comb begin
		chain[0] = '0;
		chain[0].go = go_q;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		apt_cell #(
			.CELL_IDX(apt_pkg::IDX_W'(g))
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.req(req_q),
			.age_limit(dead_q),
			.carry_in(chain[g]),
			.ins(ins),
			.carry_out(chain[g+1])
		);
	end

	// A zero name reports the insert but never occupies the slot.
	assign ins.en = fin.go && !fin.matched && is_announce && fin.free_found
		&& (req_q.peer_name != 64'd0);
	assign ins.idx = fin.free_idx;

	always_comb begin
		result_d.expired_count = fin.expired;
		priority if (fin.matched) begin
			result_d.status = apt_pkg::STATUS_OK;
			result_d.action = fin.action;
			result_d.slot_index = fin.hit_idx[3:0];
		end else if (is_announce && fin.free_found) begin
			result_d.status = apt_pkg::STATUS_OK;
			result_d.action = apt_pkg::ACT_INSERTED;
			result_d.slot_index = fin.free_idx[3:0];
		end else if (is_announce) begin
			result_d.status = apt_pkg::STATUS_FAIL;
			result_d.action = apt_pkg::ACT_FULL;
			result_d.slot_index = 4'd0;
		end else begin
			result_d.status = apt_pkg::STATUS_FAIL;
			result_d.action = apt_pkg::ACT_NOT_FOUND;
			result_d.slot_index = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= apt_pkg::DEAD_W'(30);
			busy_q <= 1'b0;
			go_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dead_q <= cfg_wdata;
			end
			go_q <= accept;
			done_q <= fin.go;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin.go) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= item;
		end
		if (fin.go) begin
			result_q <= result_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign result = result_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for aging_peer_table: a directed script, then random traffic.
// Depends on apt_pkg and the aging_peer_table RTL; expected results come from the script or a local model.
module tb_top;

	localparam int DEPTH = 16;
	localparam int POOL = 20;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 275;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		apt_pkg::in_item_t rq;
		bit typed;
		apt_pkg::out_item_t want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	apt_pkg::in_item_t req_item;
	logic cfg_we;
	logic [apt_pkg::DEAD_W-1:0] cfg_wdata;
	logic done;
	apt_pkg::out_item_t rsp_item;

	// Local copy of the table and of the dead interval.
	bit seen_valid [DEPTH];
	logic [63:0] seen_name [DEPTH];
	logic [31:0] seen_addr [DEPTH];
	logic [31:0] seen_time [DEPTH];
	logic [apt_pkg::DEAD_W-1:0] dead_secs;

	apt_pkg::out_item_t due_results [$];
	script_row_t script [$];
	int err_count;
	int stall_cycles;

	aging_peer_table #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(req_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(rsp_item)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Ages the table, then resolves the request against it.
	function automatic apt_pkg::out_item_t resolve_request(input apt_pkg::in_item_t rq);
		apt_pkg::out_item_t r;
		int unsigned aged;
		bit hit;
		logic [31:0] age;
		r = '0;
		aged = 0;
		hit = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			age = rq.now_seconds - seen_time[i];
			if (seen_valid[i] && age > {16'd0, dead_secs}) begin
				seen_valid[i] = 1'b0;
				aged++;
			end
		end
		r.expired_count = (aged > 31) ? 5'd31 : aged[4:0];
		if (rq.peer_name != '0) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!hit && seen_valid[i] && seen_name[i] == rq.peer_name
						&& seen_addr[i] == rq.peer_addr) begin
					hit = 1'b1;
					r.status = apt_pkg::STATUS_OK;
					r.slot_index = i[3:0];
					if (rq.req_type == apt_pkg::KIND_DISCONNECT) begin
						seen_valid[i] = 1'b0;
						r.action = apt_pkg::ACT_REMOVED;
					end else if (rq.req_type == apt_pkg::KIND_ANNOUNCE) begin
						seen_time[i] = rq.now_seconds;
						r.action = apt_pkg::ACT_REFRESHED;
					end else begin
						r.action = apt_pkg::ACT_NOOP;
					end
				end
			end
		end
		if (!hit && rq.req_type == apt_pkg::KIND_ANNOUNCE) begin
			r.status = apt_pkg::STATUS_FAIL;
			r.action = apt_pkg::ACT_FULL;
			r.slot_index = '0;
			for (int i = 0; i < DEPTH; i++) begin
				if (!hit && !seen_valid[i]) begin
					hit = 1'b1;
					r.status = apt_pkg::STATUS_OK;
					r.action = apt_pkg::ACT_INSERTED;
					r.slot_index = i[3:0];
					// An empty name reports the slot but never occupies it.
					if (rq.peer_name != '0) begin
						seen_valid[i] = 1'b1;
						seen_name[i] = rq.peer_name;
						seen_addr[i] = rq.peer_addr;
						seen_time[i] = rq.now_seconds;
					end
				end
			end
		end else if (!hit) begin
			r.status = apt_pkg::STATUS_FAIL;
			r.action = apt_pkg::ACT_NOT_FOUND;
			r.slot_index = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("tb_top: mismatch in %s: got %0d, want %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	task automatic add_row(input logic [7:0] kind, input logic [63:0] nm,
			input logic [31:0] ad, input logic [31:0] now, input bit typed,
			input logic st, input logic [2:0] act, input logic [3:0] slot,
			input logic [4:0] aged);
		script_row_t row;
		row.rq = '{req_type: kind, peer_name: nm, peer_addr: ad, now_seconds: now};
		row.typed = typed;
		row.want = '{status: st, action: act, slot_index: slot, expired_count: aged};
		script.push_back(row);
	endtask

	// Presents one item and holds it until the block takes it.
	task automatic push_item(input apt_pkg::in_item_t rq, input bit typed,
			input apt_pkg::out_item_t want, input bit gaps);
		apt_pkg::out_item_t got;
		if (gaps && $urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		req_item <= rq;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = resolve_request(rq);
		due_results.push_back(typed ? want : got);
	endtask

	// Drops start, lets the table drain, then writes the dead interval.
	task automatic set_dead(input logic [apt_pkg::DEAD_W-1:0] value);
		@(negedge clk);
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		dead_secs = value;
	endtask

	always @(posedge clk) begin
		apt_pkg::out_item_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with none due", rsp_item, 0);
			end else begin
				want = due_results.pop_front();
				if (rsp_item.status !== want.status)
					report_mismatch("status", rsp_item.status, want.status);
				if (rsp_item.action !== want.action)
					report_mismatch("action", rsp_item.action, want.action);
				if (rsp_item.slot_index !== want.slot_index)
					report_mismatch("slot_index", rsp_item.slot_index, want.slot_index);
				if (rsp_item.expired_count !== want.expired_count)
					report_mismatch("expired_count", rsp_item.expired_count,
						want.expired_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		logic [63:0] pool_name [POOL];
		logic [31:0] pool_addr [POOL];
		logic [apt_pkg::DEAD_W-1:0] dead_plan [PHASES];
		logic [31:0] now_s;
		logic [31:0] step;
		logic [7:0] kind;
		logic [63:0] nm;
		logic [31:0] ad;
		apt_pkg::in_item_t rq;
		int pick;
		int j;

		arst_n = 1'b0;
		start = 1'b0;
		req_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		err_count = 0;
		stall_cycles = 0;
		dead_secs = 16'd30;
		for (int i = 0; i < DEPTH; i++) begin
			seen_valid[i] = 1'b0;
			seen_name[i] = '0;
			seen_addr[i] = '0;
			seen_time[i] = '0;
		end
		// Odd pool entries share the name of their neighbor with another address.
		for (int i = 0; i < POOL; i++) begin
			pool_name[i] = (i % 2 == 1) ? pool_name[i - 1] : ({$urandom, $urandom} | 64'd1);
			pool_addr[i] = $urandom;
		end
		dead_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd12, 16'd30};
		dead_plan[3] = $urandom_range(2, 65534);

		// Directed script, run with the dead interval left at its reset value.
		add_row(apt_pkg::KIND_DISCONNECT, 64'h41, 32'h0A000001, 32'd100, 1,
			apt_pkg::STATUS_FAIL, apt_pkg::ACT_NOT_FOUND, 4'd0, 5'd0);
		add_row(apt_pkg::KIND_ANNOUNCE, 64'd0, 32'd0, 32'd100, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_INSERTED, 4'd0, 5'd0);
		add_row(apt_pkg::KIND_ANNOUNCE, '1, '1, 32'd100, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_INSERTED, 4'd0, 5'd0);
		add_row(apt_pkg::KIND_ANNOUNCE, 64'd1, 32'd0, 32'd100, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_INSERTED, 4'd1, 5'd0);
		add_row(apt_pkg::KIND_ANNOUNCE, '1, '1, 32'd110, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_REFRESHED, 4'd0, 5'd0);
		add_row(8'h7F, 64'd1, 32'd0, 32'd110, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_NOOP, 4'd1, 5'd0);
		add_row(8'hFF, 64'd1, 32'd1, 32'd110, 1,
			apt_pkg::STATUS_FAIL, apt_pkg::ACT_NOT_FOUND, 4'd0, 5'd0);
		add_row(apt_pkg::KIND_ANNOUNCE, 64'd0, 32'd9, 32'd110, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_INSERTED, 4'd2, 5'd0);
		add_row(apt_pkg::KIND_DISCONNECT, 64'd1, 32'd0, 32'd120, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_REMOVED, 4'd1, 5'd0);
		add_row(8'h80, 64'd0, 32'd0, 32'd120, 1,
			apt_pkg::STATUS_FAIL, apt_pkg::ACT_NOT_FOUND, 4'd0, 5'd0);
		// Time going backwards makes the remaining entry look ancient.
		add_row(apt_pkg::KIND_ANNOUNCE, 64'd2, 32'd5, 32'd50, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_INSERTED, 4'd0, 5'd1);
		add_row(8'd2, 64'd2, 32'd5, 32'd80, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_NOOP, 4'd0, 5'd0);
		add_row(8'd2, 64'd2, 32'd5, 32'd81, 1,
			apt_pkg::STATUS_FAIL, apt_pkg::ACT_NOT_FOUND, 4'd0, 5'd1);
		for (int i = 0; i < DEPTH; i++)
			add_row(apt_pkg::KIND_ANNOUNCE, 64'h100 + i, i, 32'd200, 0, 0, 0, 0, 0);
		add_row(apt_pkg::KIND_ANNOUNCE, 64'hDEAD, 32'd0, 32'd200, 1,
			apt_pkg::STATUS_FAIL, apt_pkg::ACT_FULL, 4'd0, 5'd0);
		add_row(apt_pkg::KIND_ANNOUNCE, 64'd0, 32'd0, 32'd200, 1,
			apt_pkg::STATUS_FAIL, apt_pkg::ACT_FULL, 4'd0, 5'd0);
		add_row(apt_pkg::KIND_DISCONNECT, 64'h100, 32'd0, 32'd230, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_REMOVED, 4'd0, 5'd0);
		add_row(8'd3, 64'h101, 32'd1, 32'd231, 1,
			apt_pkg::STATUS_FAIL, apt_pkg::ACT_NOT_FOUND, 4'd0, 5'd15);
		add_row(apt_pkg::KIND_ANNOUNCE, 64'd3, 32'd0, 32'hFFFFFFFF, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_INSERTED, 4'd0, 5'd0);
		// The age wraps across zero here: 29 minus all ones is exactly 30.
		add_row(apt_pkg::KIND_ANNOUNCE, 64'd3, 32'd0, 32'd29, 1,
			apt_pkg::STATUS_OK, apt_pkg::ACT_REFRESHED, 4'd0, 5'd0);

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[r])
			push_item(script[r].rq, script[r].typed, script[r].want, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			set_dead(dead_plan[p]);
			now_s = $urandom;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					kind = apt_pkg::KIND_ANNOUNCE;
				else if (pick < 75)
					kind = apt_pkg::KIND_DISCONNECT;
				else
					kind = $urandom_range(2, 255);
				j = $urandom_range(0, POOL - 1);
				nm = pool_name[j];
				ad = pool_addr[j];
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					nm = '0;
				end else if (pick < 10) begin
					ad = $urandom;
				end else if (pick < 18) begin
					nm = {$urandom, $urandom};
					ad = $urandom;
				end
				// Mostly short steps; some land on the dead interval, some jump anywhere.
				pick = $urandom_range(0, 99);
				if (pick < 80)
					step = $urandom_range(0, dead_secs / 6 + 1);
				else if (pick < 92)
					step = {16'd0, dead_secs} + $urandom_range(0, 2) - 1;
				else if (pick < 97)
					step = '0;
				else
					step = $urandom;
				now_s = now_s + step;
				rq = '{req_type: kind, peer_name: nm, peer_addr: ad, now_seconds: now_s};
				push_item(rq, 1'b0, '0, p != PHASES - 1);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4)
			@(posedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
